// ===== hw/rtl/wsc_pkg.sv =====
// Package for the WAV stream checker: codes, phase type and queue record.
// No dependencies.
`timescale 1ns / 1ps
package wsc_pkg;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_SKIP = 3'd2,
        PH_FMT  = 3'd3,
        PH_DATA = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_BAD_FMT   = 3'd2;
    localparam logic [2:0] ST_OFFSET    = 3'd3;
    localparam logic [2:0] ST_BAD_FORM  = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;
    localparam logic [2:0] ST_SILENT    = 3'd6;

    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [0:0] REG_FLOOR = 1'b0;
    localparam logic [0:0] REG_CHECK = 1'b1;

    // One classified byte travelling from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    localparam int QDepth = 2;

endpackage

// ===== hw/rtl/wsc_front.sv =====
// Input side of the WAV stream checker: a two-entry queue of bytes.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
module wsc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  wsc_pkg::byte_item_t s_item,
    output logic                q_valid,
    input  logic                q_ready,
    output wsc_pkg::byte_item_t q_item
);
    import wsc_pkg::*;

    byte_item_t  mem_reg [QDepth];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign s_ready = (cnt_reg != 2'(QDepth));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= s_item;
        end
    end

endmodule

// ===== hw/rtl/wsc_back.sv =====
// Parser and level statistics of the WAV stream checker, with result register.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
module wsc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  wsc_pkg::byte_item_t q_item,
    input  logic [14:0]         signal_floor,
    input  logic                check_signal,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          status_code,
    output logic [31:0]         data_start_offset,
    output logic [31:0]         data_length_bytes,
    output logic [15:0]         peak_magnitude,
    output logic [30:0]         loud_sample_count
);
    import wsc_pkg::*;

    phase_t      ph_reg, ph_next;
    logic [32:0] pos_reg, pos_next;
    logic [63:0] hs_reg, hs_next;
    logic        rok_reg, rok_next;
    logic [32:0] rem_reg, rem_next;
    logic [4:0]  fi_reg, fi_next;
    logic [15:0] ftag_reg, ftag_next, fch_reg, fch_next, fal_reg, fal_next;
    logic [15:0] fbits_reg, fbits_next;
    logic [31:0] frate_reg, frate_next, fbr_reg, fbr_next;
    logic        df_reg, df_next;
    logic [31:0] dst_reg, dst_next, dlen_reg, dlen_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] pk_reg, pk_next;
    logic [30:0] lc_reg, lc_next;
    logic [2:0]  err_reg, err_next;
    logic [3:0]  hc_reg, hc_next;
    logic [6:0]  fn_reg, fn_next;
    logic [31:0] dl_reg, dl_next;
    logic        lh_reg, lh_next;

    logic        ov_reg;
    logic [2:0]  ost_reg;
    logic [31:0] ost_off_reg, ost_len_reg;
    logic [15:0] opk_reg;
    logic [30:0] olc_reg;

    logic        take;
    logic [7:0]  b;
    logic [31:0] len, hid;
    logic [63:0] hsn;
    logic [32:0] span;
    logic [33:0] endpos;
    logic [15:0] smp, mag;
    logic [2:0]  st;
    logic        fmt_ok;

    // Only a final byte needs the result register, so other bytes keep flowing
    // while a result waits.
    assign q_ready = !q_item.last || !ov_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign b       = q_item.data;
    assign hsn     = {b, hs_reg[63:8]};
    assign hid     = hsn[31:0];
    assign len     = hsn[63:32];
    assign span    = {1'b0, len} + {32'd0, len[0]};
    assign endpos  = {1'b0, pos_next} + {1'b0, span};
    assign smp     = {b, lo_reg};
    assign mag     = smp[15] ? (16'd0 - smp) : smp;

    always_comb
    begin
        ph_next = ph_reg; pos_next = pos_reg; hs_next = hs_reg; rok_next = rok_reg;
        rem_next = rem_reg; fi_next = fi_reg; ftag_next = ftag_reg; fch_next = fch_reg;
        frate_next = frate_reg; fbr_next = fbr_reg; fal_next = fal_reg;
        fbits_next = fbits_reg; df_next = df_reg; dst_next = dst_reg; dlen_next = dlen_reg;
        lo_next = lo_reg; pk_next = pk_reg; lc_next = lc_reg; err_next = err_reg;
        hc_next = hc_reg; fn_next = fn_reg; dl_next = dl_reg; lh_next = lh_reg;

        if (!pos_reg[32])
        begin
            pos_next = pos_reg + 33'd1;
        end
        case (ph_reg)
            PH_RIFF:
            begin
                if (pos_reg == 33'd0 && b != "R") rok_next = 1'b0;
                if (pos_reg == 33'd1 && b != "I") rok_next = 1'b0;
                if ((pos_reg == 33'd2 || pos_reg == 33'd3) && b != "F") rok_next = 1'b0;
                if (pos_reg == 33'd8 && b != "W") rok_next = 1'b0;
                if (pos_reg == 33'd9 && b != "A") rok_next = 1'b0;
                if (pos_reg == 33'd10 && b != "V") rok_next = 1'b0;
                if (pos_reg == 33'd11 && b != "E") rok_next = 1'b0;
                if (pos_reg >= 33'd11)
                begin
                    if (!rok_next)
                    begin
                        err_next = ST_NOT_RIFF; ph_next = PH_DONE;
                    end
                    else
                    begin
                        ph_next = PH_HDR; hc_next = 4'd0;
                    end
                end
            end
            PH_HDR:
            begin
                hs_next = hsn;
                hc_next = hc_reg + 4'd1;
                if (hc_reg == 4'd7)
                begin
                    if (endpos > 34'h0_FFFF_FFFF)
                    begin
                        err_next = ST_OFFSET; ph_next = PH_DONE;
                    end
                    else
                    begin
                        rem_next = span;
                        ph_next  = PH_SKIP;
                        if (hid == ID_FMT)
                        begin
                            if (len < 32'd16)
                            begin
                                err_next = ST_BAD_FMT;
                            end
                            else
                            begin
                                fn_next = (len < 32'd64) ? len[6:0] : 7'd64;
                                fi_next = 5'd0;
                                ph_next = PH_FMT;
                            end
                        end
                        else if (hid == ID_DATA)
                        begin
                            dst_next = pos_next[31:0]; dlen_next = len; df_next = 1'b1;
                            pk_next = 16'd0; lc_next = 31'd0; dl_next = len;
                            lh_next = 1'b0; ph_next = PH_DATA;
                        end
                        if (err_next != ST_OK)
                        begin
                            ph_next = PH_DONE;
                        end
                        else if (span == 33'd0)
                        begin
                            ph_next = PH_HDR; hc_next = 4'd0;
                        end
                    end
                end
            end
            PH_SKIP, PH_FMT, PH_DATA:
            begin
                if (ph_reg == PH_FMT)
                begin
                    case (fi_reg)
                        5'd0: ftag_next[7:0] = b;
                        5'd1: ftag_next[15:8] = b;
                        5'd2: fch_next[7:0] = b;
                        5'd3: fch_next[15:8] = b;
                        5'd4: frate_next[7:0] = b;
                        5'd5: frate_next[15:8] = b;
                        5'd6: frate_next[23:16] = b;
                        5'd7: frate_next[31:24] = b;
                        5'd8: fbr_next[7:0] = b;
                        5'd9: fbr_next[15:8] = b;
                        5'd10: fbr_next[23:16] = b;
                        5'd11: fbr_next[31:24] = b;
                        5'd12: fal_next[7:0] = b;
                        5'd13: fal_next[15:8] = b;
                        5'd14: fbits_next[7:0] = b;
                        5'd15: fbits_next[15:8] = b;
                        default: ;
                    endcase
                    if (fi_reg < 5'd16) fi_next = fi_reg + 5'd1;
                    if (fn_reg != 7'd0) fn_next = fn_reg - 7'd1;
                end
                if (ph_reg == PH_DATA && dl_reg != 32'd0)
                begin
                    dl_next = dl_reg - 32'd1;
                    if (!lh_reg)
                    begin
                        lo_next = b; lh_next = 1'b1;
                    end
                    else
                    begin
                        lh_next = 1'b0;
                        if (mag > pk_reg) pk_next = mag;
                        if (mag > {1'b0, signal_floor} && lc_reg != 31'h7FFF_FFFF)
                        begin
                            lc_next = lc_reg + 31'd1;
                        end
                    end
                end
                if (rem_reg != 33'd0) rem_next = rem_reg - 33'd1;
                if (rem_next == 33'd0)
                begin
                    ph_next = PH_HDR; hc_next = 4'd0;
                end
            end
            default: ;
        endcase
    end

    // Final status is taken from the state after the last byte.
    assign fmt_ok = ftag_next == 16'd1 && fch_next == 16'd1 && frate_next == 32'd16000
        && fbits_next == 16'd16 && fal_next == 16'd2 && fbr_next == 32'd32000
        && df_next && !dlen_next[0];

    always_comb
    begin
        if (err_next != ST_OK) st = err_next;
        else if (ph_next == PH_RIFF) st = ST_NOT_RIFF;
        else if (ph_next == PH_FMT && fn_next != 7'd0) st = ST_BAD_FMT;
        else if (!fmt_ok) st = ST_BAD_FORM;
        else if (check_signal && ph_next == PH_DATA && dl_next != 32'd0) st = ST_TRUNC;
        else if (check_signal && lc_next == 31'd0) st = ST_SILENT;
        else st = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_RIFF; pos_reg <= '0; hs_reg <= '0; rok_reg <= 1'b1;
            rem_reg <= '0; fi_reg <= '0; ftag_reg <= '0; fch_reg <= '0;
            frate_reg <= '0; fbr_reg <= '0; fal_reg <= '0; fbits_reg <= '0;
            df_reg <= 1'b0; dst_reg <= '0; dlen_reg <= '0; pk_reg <= '0;
            lc_reg <= '0; err_reg <= '0; hc_reg <= '0; fn_reg <= '0;
            dl_reg <= '0; lh_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            if (take && q_item.last)
            begin
                ov_reg <= 1'b1;
                ph_reg <= PH_RIFF; pos_reg <= '0; hs_reg <= '0; rok_reg <= 1'b1;
                rem_reg <= '0; fi_reg <= '0; ftag_reg <= '0; fch_reg <= '0;
                frate_reg <= '0; fbr_reg <= '0; fal_reg <= '0; fbits_reg <= '0;
                df_reg <= 1'b0; dst_reg <= '0; dlen_reg <= '0; pk_reg <= '0;
                lc_reg <= '0; err_reg <= '0; hc_reg <= '0; fn_reg <= '0;
                dl_reg <= '0; lh_reg <= 1'b0;
            end
            else
            begin
                if (m_ready) ov_reg <= 1'b0;
                if (take && ph_reg != PH_DONE)
                begin
                    ph_reg <= ph_next; pos_reg <= pos_next; hs_reg <= hs_next;
                    rok_reg <= rok_next; rem_reg <= rem_next; fi_reg <= fi_next;
                    ftag_reg <= ftag_next; fch_reg <= fch_next; frate_reg <= frate_next;
                    fbr_reg <= fbr_next; fal_reg <= fal_next; fbits_reg <= fbits_next;
                    df_reg <= df_next; dst_reg <= dst_next; dlen_reg <= dlen_next;
                    pk_reg <= pk_next; lc_reg <= lc_next; err_reg <= err_next;
                    hc_reg <= hc_next; fn_reg <= fn_next; dl_reg <= dl_next;
                    lh_reg <= lh_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) lo_reg <= lo_next;
        if (take && q_item.last)
        begin
            ost_reg     <= (ph_reg == PH_DONE) ? err_reg : st;
            ost_off_reg <= (ph_reg == PH_DONE || st != ST_OK) ? 32'd0 : dst_next;
            ost_len_reg <= (ph_reg == PH_DONE || st != ST_OK) ? 32'd0 : dlen_next;
            opk_reg     <= (ph_reg != PH_DONE && st == ST_OK && check_signal)
                           ? pk_next : 16'd0;
            olc_reg     <= (ph_reg != PH_DONE && st == ST_OK && check_signal)
                           ? lc_next : 31'd0;
        end
    end

    assign m_valid           = ov_reg;
    assign status_code       = ost_reg;
    assign data_start_offset = ost_off_reg;
    assign data_length_bytes = ost_len_reg;
    assign peak_magnitude    = opk_reg;
    assign loud_sample_count = olc_reg;

endmodule

// ===== hw/rtl/wav_stream_check_and_level_stats.sv =====
// Top level of the WAV stream checker with level statistics.
// Depends on wsc_pkg, wsc_front and wsc_back.
`timescale 1ns / 1ps
// The block takes a WAV file one byte per transaction, tlast on the final byte,
// checks the RIFF/WAVE header, walks the chunks, keeps the last fmt and data
// chunk, and tracks peak magnitude and loud sample count over the data body.
// One byte is taken every clock cycle, but a final byte waits while the
// previous result is not taken. A two-entry queue sits in front of the
// parser and the result is held in an output register, so a new file can
// start while the previous result waits. One result transaction follows
// each tlast byte. Registers: signal_floor at 0x0, check_signal at 0x4.
module wav_stream_check_and_level_stats
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  logic         s_axis_tlast,   // end_of_stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status_code, [34:3] data_start_offset, [66:35] data_length_bytes,
    // [82:67] peak_magnitude, [113:83] loud_sample_count, [119:114] zero
    output logic [119:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import wsc_pkg::*;

    logic [14:0] floor_reg;
    logic        chk_reg;
    byte_item_t  s_item, q_item;
    logic        q_valid, q_ready;
    logic [2:0]  st;
    logic [31:0] off, len;
    logic [15:0] pk;
    logic [30:0] lc;

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            REG_FLOOR: prdata = {17'd0, floor_reg};
            REG_CHECK: prdata = {31'd0, chk_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= 15'd200;
            chk_reg   <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_FLOOR) floor_reg <= pwdata[14:0];
            else chk_reg <= pwdata[0];
        end
    end

    assign s_item.data = s_axis_tdata;
    assign s_item.last = s_axis_tlast;

    wsc_front u_front
    (
        .clk(clk), .rst_n(rst_n), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .s_item(s_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    wsc_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .signal_floor(floor_reg), .check_signal(chk_reg),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .status_code(st),
        .data_start_offset(off), .data_length_bytes(len), .peak_magnitude(pk),
        .loud_sample_count(lc)
    );

    assign m_axis_tdata = {6'd0, lc, pk, len, off, st};

    // A non-ok result carries no chunk information.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && st != ST_OK) |-> (off == 32'd0 && lc == 31'd0))
        else $error("non-ok result with nonzero fields");

    // Peak cannot exceed full scale of a 16-bit sample.
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pk <= 16'd32768))
        else $error("peak above 32768");

    // A stalled result does not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

// ===== tb/tb_wav_stream_check_and_level_stats.sv =====
// Testbench for the WAV stream checker with level statistics.
// Depends on wsc_pkg and the wav_stream_check_and_level_stats RTL.
`timescale 1ns / 1ps
module tb_wav_stream_check_and_level_stats;
    import wsc_pkg::*;

    // One expected verdict for a file, in the layout of the result bus.
    typedef struct packed {
        logic [30:0] loud_count;
        logic [15:0] peak;
        logic [31:0] body_length;
        logic [31:0] body_offset;
        logic [2:0]  status;
    } verdict_t;

    // One byte of a file as it waits for the stream input.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] in_byte
    logic         s_axis_tlast;   // end_of_stream
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [2:0] status_code, [34:3] data_start_offset, [66:35] data_length_bytes,
    // [82:67] peak_magnitude, [113:83] loud_sample_count, [119:114] zero
    logic [119:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    wav_stream_check_and_level_stats dut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bytes waiting for the driver and verdicts waiting for the monitor.
    file_byte_t pending_bytes[$];
    verdict_t   pending_verdicts[$];
    int         mismatches;
    logic       quiet_stretch;   // when set, neither side inserts idle cycles
    logic       in_taken = 1'b0; // the presented byte completed at the last edge

    // Predictor copy of the configuration registers.
    logic [14:0] p_floor;
    logic        p_check;

    // Predictor copy of the parser state.
    phase_t      p_phase;
    logic [32:0] p_pos;
    logic [63:0] p_shift;
    logic        p_riff_ok;
    logic [32:0] p_chunk_left;
    logic [4:0]  p_fmt_idx;
    logic [15:0] p_fmt_tag, p_chans, p_align, p_bits;
    logic [31:0] p_rate, p_byte_rate;
    logic        p_have_data;
    logic [31:0] p_data_start, p_data_len;
    logic [7:0]  p_low_byte;
    logic [15:0] p_peak;
    logic [30:0] p_loud;
    logic [2:0]  p_error;
    logic [3:0]  p_hdr_cnt;
    logic [6:0]  p_fmt_needed;
    logic [32:0] p_data_left;
    logic        p_low_held;

    function automatic void clear_parser();
        p_phase = PH_RIFF; p_pos = '0; p_shift = '0; p_riff_ok = 1'b1;
        p_chunk_left = '0; p_fmt_idx = '0; p_fmt_tag = '0; p_chans = '0;
        p_align = '0; p_bits = '0; p_rate = '0; p_byte_rate = '0;
        p_have_data = 1'b0; p_data_start = '0; p_data_len = '0; p_low_byte = '0;
        p_peak = '0; p_loud = '0; p_error = ST_OK; p_hdr_cnt = '0;
        p_fmt_needed = '0; p_data_left = '0; p_low_held = 1'b0;
    endfunction

    function automatic void latch_error(logic [2:0] code);
        p_error = code;
        p_phase = PH_DONE;
    endfunction

    // A full 8-byte chunk header has arrived: decide where the body goes.
    function automatic void open_chunk();
        logic [31:0] id;
        logic [33:0] len, span;
        id = p_shift[31:0];
        len = {2'b0, p_shift[63:32]};
        span = len + len[0];
        if ({1'b0, p_pos} + span > 34'hFFFF_FFFF)
        begin
            latch_error(ST_OFFSET);
            return;
        end
        p_chunk_left = span[32:0];
        p_phase = PH_SKIP;
        if (id == ID_FMT)
        begin
            if (len < 16)
            begin
                latch_error(ST_BAD_FMT);
                return;
            end
            p_fmt_needed = (len < 64) ? len[6:0] : 7'd64;
            p_fmt_idx = '0;
            p_phase = PH_FMT;
        end
        else if (id == ID_DATA)
        begin
            p_data_start = p_pos[31:0];
            p_data_len = len[31:0];
            p_have_data = 1'b1;
            p_peak = '0;
            p_loud = '0;
            p_data_left = len[32:0];
            p_low_held = 1'b0;
            p_phase = PH_DATA;
        end
        if (p_chunk_left == 0)
        begin
            p_phase = PH_HDR;
            p_hdr_cnt = '0;
        end
    endfunction

    function automatic void grab_fmt_byte(logic [7:0] b);
        case (p_fmt_idx)
            0: p_fmt_tag[7:0] = b;
            1: p_fmt_tag[15:8] = b;
            2: p_chans[7:0] = b;
            3: p_chans[15:8] = b;
            4: p_rate[7:0] = b;
            5: p_rate[15:8] = b;
            6: p_rate[23:16] = b;
            7: p_rate[31:24] = b;
            8: p_byte_rate[7:0] = b;
            9: p_byte_rate[15:8] = b;
            10: p_byte_rate[23:16] = b;
            11: p_byte_rate[31:24] = b;
            12: p_align[7:0] = b;
            13: p_align[15:8] = b;
            14: p_bits[7:0] = b;
            15: p_bits[15:8] = b;
            default: ;
        endcase
        if (p_fmt_idx < 16) p_fmt_idx++;
        if (p_fmt_needed > 0) p_fmt_needed--;
    endfunction

    function automatic void grab_sample_byte(logic [7:0] b);
        logic [15:0] s;
        logic [16:0] mag;
        if (!p_low_held)
        begin
            p_low_byte = b;
            p_low_held = 1'b1;
            return;
        end
        p_low_held = 1'b0;
        s = {b, p_low_byte};
        mag = s[15] ? 17'h10000 - s : {1'b0, s};
        if (mag > p_peak) p_peak = mag[15:0];
        if (mag > p_floor && p_loud != 31'h7FFF_FFFF) p_loud++;
    endfunction

    function automatic logic [2:0] file_status();
        if (p_error != ST_OK) return p_error;
        if (p_phase == PH_RIFF) return ST_NOT_RIFF;
        if (p_phase == PH_FMT && p_fmt_needed > 0) return ST_BAD_FMT;
        if (p_fmt_tag != 1 || p_chans != 1 || p_rate != 16000 || p_bits != 16 ||
            p_align != 2 || p_byte_rate != 32000 || !p_have_data || p_data_len[0])
            return ST_BAD_FORM;
        if (p_check)
        begin
            if (p_phase == PH_DATA && p_data_left > 0) return ST_TRUNC;
            if (p_loud == 0) return ST_SILENT;
        end
        return ST_OK;
    endfunction

    // Feeds one byte to the predictor; a final byte queues the verdict.
    function automatic void parse_byte(file_byte_t fb);
        logic [32:0] at;
        logic [7:0]  tag_byte;
        verdict_t    v;
        at = p_pos;
        if (!p_pos[32]) p_pos++;
        case (p_phase)
            PH_RIFF:
            begin
                case (at)
                    0: tag_byte = "R";
                    1: tag_byte = "I";
                    2, 3: tag_byte = "F";
                    8: tag_byte = "W";
                    9: tag_byte = "A";
                    10: tag_byte = "V";
                    default: tag_byte = "E";
                endcase
                if (at < 12 && (at < 4 || at >= 8) && fb.data != tag_byte)
                    p_riff_ok = 1'b0;
                if (at >= 11)
                begin
                    if (!p_riff_ok) latch_error(ST_NOT_RIFF);
                    else
                    begin
                        p_phase = PH_HDR;
                        p_hdr_cnt = '0;
                    end
                end
            end
            PH_HDR:
            begin
                p_shift = {fb.data, p_shift[63:8]};
                p_hdr_cnt++;
                if (p_hdr_cnt >= 8) open_chunk();
            end
            PH_SKIP, PH_FMT, PH_DATA:
            begin
                if (p_phase == PH_FMT) grab_fmt_byte(fb.data);
                if (p_phase == PH_DATA && p_data_left > 0)
                begin
                    grab_sample_byte(fb.data);
                    p_data_left--;
                end
                if (p_chunk_left > 0) p_chunk_left--;
                if (p_chunk_left == 0)
                begin
                    p_phase = PH_HDR;
                    p_hdr_cnt = '0;
                end
            end
            default: ;
        endcase
        if (!fb.last) return;
        v = '0;
        v.status = file_status();
        if (v.status == ST_OK)
        begin
            v.body_offset = p_data_start;
            v.body_length = p_data_len;
            if (p_check)
            begin
                v.peak = p_peak;
                v.loud_count = p_loud;
            end
        end
        pending_verdicts.push_back(v);
        clear_parser();
    endfunction

    // ---------------------------------------------------------------------
    // Driver: presents queued bytes; the predictor sees each byte the
    // moment its transaction completes at the rising edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            parse_byte('{data: s_axis_tdata, last: s_axis_tlast});
            void'(pending_bytes.pop_front());
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else if (s_axis_tvalid && !in_taken)
        begin
            // A byte that is still waiting stays on the bus unchanged.
            s_axis_tvalid <= 1'b1;
        end
        else if (pending_bytes.size() > 0 &&
                 (quiet_stretch || $urandom_range(99) >= 17))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_bytes[0].data;
            s_axis_tlast  <= pending_bytes[0].last;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random back-pressure, and a field-by-field compare of every
    // result transaction against the oldest queued verdict.
    // ---------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= quiet_stretch || $urandom_range(99) >= 17;
    end

    always @(posedge clk)
    begin
        verdict_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[113:0];
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.status != want.status || got.body_offset != want.body_offset ||
                    got.body_length != want.body_length || got.peak != want.peak ||
                    got.loud_count != want.loud_count || m_axis_tdata[119:114] != 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Result mismatch: status %0d/%0d offset %h/%h ",
                                  "len %h/%h peak %0d/%0d loud %0d/%0d ",
                                  "(expected/actual)"},
                                 want.status, got.status, want.body_offset,
                                 got.body_offset, want.body_length, got.body_length,
                                 want.peak, got.peak, want.loud_count, got.loud_count);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // File builders. Every file is pushed byte by byte, tlast on the final.
    // ---------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] b, logic last = 1'b0);
        pending_bytes.push_back('{data: b, last: last});
    endfunction

    function automatic void push_word(logic [31:0] w, int n);
        for (int i = 0; i < n; i++) push_byte(w[8*i +: 8]);
    endfunction

    function automatic void push_riff_head();
        push_word("FFIR", 4);
        push_word($urandom, 4);
        push_word("EVAW", 4);
    endfunction

    // fmt chunk with the given fields; extra body bytes follow if len > 16.
    function automatic void push_fmt(logic [31:0] len, logic [15:0] tag, logic [15:0] ch,
                                     logic [31:0] rate, logic [31:0] brate,
                                     logic [15:0] align, logic [15:0] bits);
        push_word(ID_FMT, 4);
        push_word(len, 4);
        push_word(tag, 2); push_word(ch, 2); push_word(rate, 4);
        push_word(brate, 4); push_word(align, 2); push_word(bits, 2);
        for (int i = 16; i < len; i++) push_byte(8'($urandom));
        if (len[0]) push_byte(8'($urandom));
    endfunction

    function automatic void push_good_fmt();
        push_fmt(16, 1, 1, 16000, 32000, 2, 16);
    endfunction

    // Data chunk of declared length len; only 'given' body bytes are sent.
    // Samples are random with the given magnitude range.
    function automatic void push_data(logic [31:0] len, int given, int loudness);
        logic [15:0] s;
        push_word(ID_DATA, 4);
        push_word(len, 4);
        for (int i = 0; i < given; i += 2)
        begin
            case (loudness)
                0: s = 16'($urandom_range(0, 3) - 1);
                1: s = 16'($urandom);
                default: s = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
            endcase
            push_byte(s[7:0]);
            if (i + 1 < given) push_byte(s[15:8]);
        end
    endfunction

    function automatic void push_junk_chunk(int len);
        push_word($urandom, 4);
        push_word(len, 4);
        for (int i = 0; i < len + (len & 1); i++) push_byte(8'($urandom));
    endfunction

    // Marks the last queued byte as the end of the file.
    function automatic void end_file();
        file_byte_t fb;
        fb = pending_bytes.pop_back();
        fb.last = 1'b1;
        pending_bytes.push_back(fb);
    endfunction

    // Random file: mostly well formed, sometimes broken in one way.
    function automatic void push_random_file();
        int n, flaw;
        flaw = $urandom_range(0, 9);
        push_riff_head();
        if ($urandom_range(1)) push_junk_chunk($urandom_range(0, 5));
        case (flaw)
            1: push_fmt(16, 16'($urandom_range(0, 2)), 1, 16000, 32000, 2, 16);
            2: push_fmt(16, 1, 1, $urandom_range(1) ? 16000 : $urandom, 32000,
                        16'($urandom_range(1, 2)), $urandom_range(0, 1) ? 16 : 8);
            3: push_fmt($urandom_range(17, 21), 1, 1, 16000, 32000, 2, 16);
            default: push_good_fmt();
        endcase
        n = 2 * $urandom_range(0, 12);
        if (flaw == 4) n++;
        push_data(n, (flaw == 5) ? n / 2 : n, $urandom_range(0, 2));
        if (flaw == 4) push_byte(8'($urandom));
        if (flaw == 6) push_junk_chunk($urandom_range(0, 3));
        if (flaw == 7) push_word($urandom, $urandom_range(1, 7));
        if (pending_bytes.size() == 0 || flaw == 8) push_byte(8'($urandom));
        if (flaw == 9) push_good_fmt();
        end_file();
    endfunction

    // Register writes go out only with nothing in flight.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        wait (pending_bytes.size() == 0 && pending_verdicts.size() == 0);
        repeat (8) @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr[2] == REG_FLOOR) p_floor = value[14:0];
        else p_check = value[0];
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_bytes.size() == 0 && pending_verdicts.size() == 0);
    endtask

    initial
    begin
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0;
        quiet_stretch = 1'b0;
        p_floor = 15'd200;
        p_check = 1'b1;
        clear_parser();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed files: each special case once.
        push_byte(8'hFF, 1'b1);                                 // short file
        push_word("FFIR", 4); push_word(0, 3); end_file();      // short file
        push_word("XFIR", 4); push_word(0, 4); push_word("EVAW", 4); end_file();
        push_riff_head(); push_good_fmt(); push_data(8, 8, 2); end_file();
        push_riff_head(); push_good_fmt(); push_data(8, 8, 2);
        push_word(0, 5); end_file();                            // partial header
        push_riff_head(); push_fmt(15, 1, 1, 16000, 32000, 2, 16); end_file();
        push_riff_head(); push_fmt(40, 1, 1, 16000, 32000, 2, 16);
        repeat (30) void'(pending_bytes.pop_back());
        end_file();                                             // fmt cut short
        push_riff_head(); push_word(ID_DATA, 4); push_word(32'hFFFF_FFF0, 4);
        push_byte(0); end_file();                               // offset too large
        push_riff_head(); push_word(ID_DATA, 4); push_word(32'hFFFF_FFE9, 4);
        push_byte(0); end_file();                               // odd length plus pad
        push_riff_head(); push_good_fmt(); push_data(5, 5, 1);
        push_byte(0); end_file();                               // odd data length
        push_riff_head(); push_good_fmt(); push_data(2, 0, 1); end_file();
        push_riff_head(); push_data(4, 4, 1); end_file();       // missing fmt
        push_riff_head(); push_good_fmt(); push_data(8, 4, 2); end_file();
        push_riff_head(); push_good_fmt(); push_data(8, 8, 0); end_file();
        push_riff_head(); push_good_fmt(); push_data(0, 0, 0); end_file();
        push_riff_head(); push_good_fmt();
        push_word(ID_DATA, 4); push_word(4, 4); push_word(32'h8000_8000, 4);
        push_data(2, 2, 2); end_file();                         // last data wins
        wait_drained();

        write_reg(3'd0, 32'h7FFF);
        write_reg(3'd4, 0);
        push_riff_head(); push_good_fmt(); push_data(8, 4, 0); end_file();
        push_riff_head(); push_good_fmt(); push_data(4, 4, 2); end_file();
        wait_drained();
        write_reg(3'd0, 0);
        write_reg(3'd4, 1);
        push_riff_head(); push_good_fmt(); push_data(6, 6, 0); end_file();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_reg(3'd0, (ph == 1) ? 32'h7FFF : (ph == 2) ? 0 : $urandom_range(0, 2000));
            write_reg(3'd4, (ph % 3 == 2) ? 0 : 1);
            quiet_stretch = (ph == 3);
            push_random_file();
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wsc_pkg.sv
hw/rtl/wsc_front.sv
hw/rtl/wsc_back.sv
hw/rtl/wav_stream_check_and_level_stats.sv
tb/tb_wav_stream_check_and_level_stats.sv
